### sv/dlpf_pkg.sv
// dlpf_pkg: shared types, character codes and helper functions for the
// debug link packet framer; no dependencies
`default_nettype none

package dlpf_pkg;

    // operation codes
    localparam logic [1:0] OP_TX_BYTE  = 2'd0;
    localparam logic [1:0] OP_TX_CLOSE = 2'd1;
    localparam logic [1:0] OP_RX_BYTE  = 2'd2;

    // receive phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FIRST = 3'd1;
    localparam logic [2:0] PH_SKIP  = 3'd2;
    localparam logic [2:0] PH_HIGH  = 3'd3;
    localparam logic [2:0] PH_LOW   = 3'd4;

    // channel codes
    localparam logic CH_LINK    = 1'b0;
    localparam logic CH_CONSOLE = 1'b1;

    // framing characters
    localparam logic [7:0] CHR_START   = 8'h24;
    localparam logic [7:0] CHR_END     = 8'h23;
    localparam logic [7:0] CHR_ACK     = 8'h2B;
    localparam logic [7:0] CHR_CONSOLE = 8'h4F;

    // result group sizing
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic       tx_open;
        logic [7:0] tx_sum;
        logic [2:0] rx_phase;
        logic [3:0] rx_high_nibble;
        logic       rx_high_bad;
    } state_t;

    // all results caused by one item
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic                            channel;
        logic                            hex_error;
        logic [MAX_RESULTS-1:0][7:0]     bytes;
    } group_t;

    // upper-case hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    // value of a hex character, bit 4 set when it is not a hex digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] r;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b0, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        else
        begin
            r = 5'h10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/dlpf_if.sv
// dlpf_cmd_if and dlpf_res_if: valid/ready channels of the packet framer
// depends on nothing but the field widths of the work items
`default_nettype none

interface dlpf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface dlpf_res_if;
    logic       valid;
    logic       ready;
    logic       channel;
    logic [7:0] out_byte;
    logic       hex_error;
    logic       run_last;

    modport source (output valid, output channel, output out_byte, output hex_error,
                    output run_last, input ready);
    modport sink (input valid, input channel, input out_byte, input hex_error,
                  input run_last, output ready);
endinterface

`default_nettype wire

### sv/dlpf_step.sv
// dlpf_step: single-pass framing and deframing logic for one item
// depends on dlpf_pkg
`default_nettype none

module dlpf_step
(
    input  wire logic [1:0]      operation,
    input  wire logic [7:0]      data_byte,
    input  wire dlpf_pkg::state_t st,
    output dlpf_pkg::state_t     st_next,
    output dlpf_pkg::group_t     grp
);

    logic [4:0] dv;
    logic [7:0] sum_next;

    assign dv       = dlpf_pkg::digit_value(data_byte);
    assign sum_next = st.tx_sum + data_byte;

    always_comb
    begin
        st_next       = st;
        grp.count     = '0;
        grp.channel   = dlpf_pkg::CH_LINK;
        grp.hex_error = 1'b0;
        grp.bytes     = '0;
        case (operation)
            // payload byte, open the packet first if needed
            dlpf_pkg::OP_TX_BYTE:
            begin
                if (!st.tx_open)
                begin
                    grp.count      = dlpf_pkg::CNT_W'(2);
                    grp.bytes[0]   = dlpf_pkg::CHR_START;
                    grp.bytes[1]   = data_byte;
                    st_next.tx_sum = data_byte;
                end
                else
                begin
                    grp.count      = dlpf_pkg::CNT_W'(1);
                    grp.bytes[0]   = data_byte;
                    st_next.tx_sum = sum_next;
                end
                st_next.tx_open = 1'b1;
            end
            // close: trailer with checksum, empty packet if none open
            dlpf_pkg::OP_TX_CLOSE:
            begin
                if (!st.tx_open)
                begin
                    grp.count    = dlpf_pkg::CNT_W'(4);
                    grp.bytes[0] = dlpf_pkg::CHR_START;
                    grp.bytes[1] = dlpf_pkg::CHR_END;
                    grp.bytes[2] = dlpf_pkg::hex_char(st.tx_sum[7:4]);
                    grp.bytes[3] = dlpf_pkg::hex_char(st.tx_sum[3:0]);
                end
                else
                begin
                    grp.count    = dlpf_pkg::CNT_W'(3);
                    grp.bytes[0] = dlpf_pkg::CHR_END;
                    grp.bytes[1] = dlpf_pkg::hex_char(st.tx_sum[7:4]);
                    grp.bytes[2] = dlpf_pkg::hex_char(st.tx_sum[3:0]);
                end
                st_next.tx_open = 1'b0;
                st_next.tx_sum  = '0;
            end
            // received link byte
            dlpf_pkg::OP_RX_BYTE:
            begin
                if (data_byte == dlpf_pkg::CHR_START)
                begin
                    grp.count              = dlpf_pkg::CNT_W'(1);
                    grp.bytes[0]           = dlpf_pkg::CHR_ACK;
                    st_next.rx_phase       = dlpf_pkg::PH_FIRST;
                    st_next.rx_high_nibble = '0;
                    st_next.rx_high_bad    = 1'b0;
                end
                else
                begin
                    case (st.rx_phase)
                        dlpf_pkg::PH_FIRST:
                        begin
                            if (data_byte == dlpf_pkg::CHR_CONSOLE)
                            begin
                                st_next.rx_phase = dlpf_pkg::PH_HIGH;
                            end
                            else if (data_byte == dlpf_pkg::CHR_END)
                            begin
                                st_next.rx_phase = dlpf_pkg::PH_IDLE;
                            end
                            else
                            begin
                                st_next.rx_phase = dlpf_pkg::PH_SKIP;
                            end
                        end
                        dlpf_pkg::PH_SKIP:
                        begin
                            if (data_byte == dlpf_pkg::CHR_END)
                            begin
                                st_next.rx_phase = dlpf_pkg::PH_IDLE;
                            end
                        end
                        dlpf_pkg::PH_HIGH:
                        begin
                            if (data_byte == dlpf_pkg::CHR_END)
                            begin
                                st_next.rx_phase = dlpf_pkg::PH_IDLE;
                            end
                            else
                            begin
                                st_next.rx_high_nibble = dv[3:0];
                                st_next.rx_high_bad    = dv[4];
                                st_next.rx_phase       = dlpf_pkg::PH_LOW;
                            end
                        end
                        dlpf_pkg::PH_LOW:
                        begin
                            grp.count              = dlpf_pkg::CNT_W'(1);
                            grp.channel            = dlpf_pkg::CH_CONSOLE;
                            grp.hex_error          = st.rx_high_bad | dv[4];
                            grp.bytes[0]           = {st.rx_high_nibble, dv[3:0]};
                            st_next.rx_high_nibble = '0;
                            st_next.rx_high_bad    = 1'b0;
                            if (data_byte == dlpf_pkg::CHR_END)
                            begin
                                st_next.rx_phase = dlpf_pkg::PH_IDLE;
                            end
                            else
                            begin
                                st_next.rx_phase = dlpf_pkg::PH_HIGH;
                            end
                        end
                        default:
                        begin
                            st_next.rx_phase = dlpf_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/dlpf_out_queue.sv
// dlpf_out_queue: result group register that hands out one item per cycle
// while res.ready is high; depends on dlpf_pkg and dlpf_res_if
`default_nettype none

module dlpf_out_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire dlpf_pkg::group_t  grp_in,
    output logic                   can_load,
    dlpf_res_if.source             res
);

    logic                          grp_valid_reg;
    dlpf_pkg::group_t              grp_reg;
    logic [dlpf_pkg::IDX_W-1:0]    idx_reg;
    logic                          last;
    logic                          take;

    // last result of the held group
    assign last     = ({1'b0, idx_reg} == (grp_reg.count - dlpf_pkg::CNT_W'(1)));
    assign take     = res.valid && res.ready;
    assign can_load = !grp_valid_reg || (take && last);

    // output fields
    assign res.valid     = grp_valid_reg;
    assign res.channel   = grp_reg.channel;
    assign res.out_byte  = grp_reg.bytes[idx_reg];
    assign res.hex_error = grp_reg.hex_error;
    assign res.run_last  = last;

    // group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            grp_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                grp_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + dlpf_pkg::IDX_W'(1);
            end
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp_in;
        end
    end

endmodule

`default_nettype wire

### sv/debug_link_packet_framer_unit.sv
// debug_link_packet_framer_unit: packet framer top level, input register,
// protocol state and result queue; depends on dlpf_pkg, dlpf_if, dlpf_step, dlpf_out_queue
// the first result is valid once the item has passed the input register and result queue
// throughput: one item per cycle while each item gives at most one result
//   and res.ready is high; an item with more results holds the queue until all are taken
// reset: rst_n asynchronous active low, clears framer state and both stages
`default_nettype none

module debug_link_packet_framer_unit
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dlpf_cmd_if.sink    cmd,
    dlpf_res_if.source  res
);

    logic                s1_valid_reg;
    logic [1:0]          s1_op_reg;
    logic [7:0]          s1_byte_reg;
    dlpf_pkg::state_t    state_reg;
    dlpf_pkg::state_t    state_next;
    dlpf_pkg::group_t    grp;
    logic                can_load;
    logic                has_results;
    logic                s1_advance;

    // an item leaves the input register once its results fit in the queue
    assign has_results = (grp.count != '0);
    assign s1_advance  = s1_valid_reg && (!has_results || can_load);
    assign cmd.ready   = !s1_valid_reg || s1_advance;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_op_reg   <= cmd.operation;
            s1_byte_reg <= cmd.data_byte;
        end
    end

    // framer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{tx_open: 1'b0, tx_sum: 8'd0, rx_phase: dlpf_pkg::PH_IDLE,
                           rx_high_nibble: 4'd0, rx_high_bad: 1'b0};
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    dlpf_step u_step
    (
        .operation (s1_op_reg),
        .data_byte (s1_byte_reg),
        .st        (state_reg),
        .st_next   (state_next),
        .grp       (grp)
    );

    dlpf_out_queue u_out_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_advance && has_results),
        .grp_in   (grp),
        .can_load (can_load),
        .res      (res)
    );

`ifndef NO_ASSERTIONS
    // no running sum survives outside an open packet
    a_sum_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.tx_open |-> (state_reg.tx_sum == 8'd0))
        else $error("transmit sum nonzero with no packet open");

    // decode errors only appear on console items
    a_err_console: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.hex_error) |-> (res.channel == dlpf_pkg::CH_CONSOLE))
        else $error("hex error on a link item");

    // an item that produced results reaches the output in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && has_results) |=> res.valid)
        else $error("loaded result group not presented");
`endif

endmodule

`default_nettype wire

### bench/debug_link_packet_framer_unit_tb.sv
// debug_link_packet_framer_unit_tb: self-checking bench for the packet framer
// predicts framed link bytes, acks and decoded console bytes from each item
// depends on dlpf_pkg, dlpf_if and debug_link_packet_framer_unit

module debug_link_packet_framer_unit_tb;

    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_ITEMS = 460;

    // idling modes
    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  data;
        int unsigned mode;
    } link_item_t;

    typedef struct packed {
        logic       channel;
        logic [7:0] out_byte;
        logic       hex_error;
        logic       run_last;
    } framer_result_t;

    logic clk;
    logic rst_n;

    dlpf_cmd_if cmd_ch();
    dlpf_res_if res_ch();

    link_item_t     pending_items[$];
    framer_result_t due_results[$];
    framer_result_t next_due;

    int unsigned items_total;
    int unsigned items_taken;
    int unsigned random_taken;
    int unsigned stall_mode;
    int unsigned quiet_cycles;
    int unsigned error_count;

    // predicted framer state
    logic       tx_open;
    logic [7:0] tx_sum;
    logic [2:0] rx_phase;
    logic [3:0] held_nibble;
    logic       held_bad;

    debug_link_packet_framer_unit DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned send_gap_pct(input int unsigned mode);
        return (mode == MODE_SEND) ? 78 : (mode == MODE_BOTH) ? 10 : 0;
    endfunction

    function automatic int unsigned recv_stall_pct(input int unsigned mode);
        return (mode == MODE_RECV) ? 78 : (mode == MODE_BOTH) ? 10 : 0;
    endfunction

    // value of one hex character, either case; bad set when not a hex digit
    function automatic logic [3:0] nibble_of(input logic [7:0] c, output logic bad);
        bad = 1'b0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            return 4'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            return 4'(c - 8'h61 + 8'd10);
        end
        bad = 1'b1;
        return 4'd0;
    endfunction

    // upper-case ascii of a checksum nibble
    function automatic logic [7:0] sum_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + nib : 8'h41 + (nib - 4'd10);
    endfunction

    function automatic framer_result_t link_byte(input logic [7:0] b);
        return '{dlpf_pkg::CH_LINK, b, 1'b0, 1'b0};
    endfunction

    // works out the results of one accepted item and queues them
    task automatic frame_item(input logic [1:0] op, input logic [7:0] b);
        framer_result_t outs[$];
        logic [3:0]     lo_nib;
        logic           lo_bad;
        case (op)
            dlpf_pkg::OP_TX_BYTE:
            begin
                if (!tx_open)
                begin
                    outs.push_back(link_byte(dlpf_pkg::CHR_START));
                    tx_open = 1'b1;
                    tx_sum  = 8'd0;
                end
                outs.push_back(link_byte(b));
                tx_sum = tx_sum + b;
            end
            dlpf_pkg::OP_TX_CLOSE:
            begin
                if (!tx_open)
                begin
                    outs.push_back(link_byte(dlpf_pkg::CHR_START));
                end
                outs.push_back(link_byte(dlpf_pkg::CHR_END));
                outs.push_back(link_byte(sum_digit(tx_sum[7:4])));
                outs.push_back(link_byte(sum_digit(tx_sum[3:0])));
                tx_open = 1'b0;
                tx_sum  = 8'd0;
            end
            dlpf_pkg::OP_RX_BYTE:
            begin
                if (b == dlpf_pkg::CHR_START)
                begin
                    outs.push_back(link_byte(dlpf_pkg::CHR_ACK));
                    rx_phase    = dlpf_pkg::PH_FIRST;
                    held_nibble = 4'd0;
                    held_bad    = 1'b0;
                end
                else
                begin
                    case (rx_phase)
                        dlpf_pkg::PH_FIRST:
                        begin
                            if (b == dlpf_pkg::CHR_CONSOLE)
                                rx_phase = dlpf_pkg::PH_HIGH;
                            else if (b == dlpf_pkg::CHR_END)
                                rx_phase = dlpf_pkg::PH_IDLE;
                            else
                                rx_phase = dlpf_pkg::PH_SKIP;
                        end
                        dlpf_pkg::PH_SKIP:
                        begin
                            if (b == dlpf_pkg::CHR_END)
                                rx_phase = dlpf_pkg::PH_IDLE;
                        end
                        dlpf_pkg::PH_HIGH:
                        begin
                            if (b == dlpf_pkg::CHR_END)
                            begin
                                rx_phase = dlpf_pkg::PH_IDLE;
                            end
                            else
                            begin
                                held_nibble = nibble_of(b, held_bad);
                                rx_phase    = dlpf_pkg::PH_LOW;
                            end
                        end
                        dlpf_pkg::PH_LOW:
                        begin
                            lo_nib = nibble_of(b, lo_bad);
                            outs.push_back('{dlpf_pkg::CH_CONSOLE, {held_nibble, lo_nib},
                                             held_bad | lo_bad, 1'b0});
                            rx_phase    = (b == dlpf_pkg::CHR_END) ? dlpf_pkg::PH_IDLE
                                                                   : dlpf_pkg::PH_HIGH;
                            held_nibble = 4'd0;
                            held_bad    = 1'b0;
                        end
                        default:
                        begin
                            rx_phase = dlpf_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        if (outs.size() > 0)
        begin
            outs[outs.size() - 1].run_last = 1'b1;
        end
        foreach (outs[i])
        begin
            due_results.push_back(outs[i]);
        end
    endtask

    task automatic add_item(input logic [1:0] op, input logic [7:0] b,
                            input int unsigned mode);
        pending_items.push_back('{op, b, mode});
        items_total++;
        if (op != OP_NOP)
        begin
            random_taken++;
        end
    endtask

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'h30 + 8'(v);
        else if ($urandom_range(0, 1) == 0)
            return 8'h41 + 8'(v - 10);
        return 8'h61 + 8'(v - 10);
    endfunction

    // any byte except the start and end marks
    function automatic logic [7:0] rand_plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == dlpf_pkg::CHR_START || c == dlpf_pkg::CHR_END)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // payload bytes, mostly closed
    task automatic add_tx_packet(input int unsigned mode);
        int unsigned n;
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            add_item(dlpf_pkg::OP_TX_BYTE, 8'($urandom_range(0, 255)), mode);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            add_item(dlpf_pkg::OP_TX_CLOSE, 8'($urandom_range(0, 255)), mode);
        end
    endtask

    // console packet with hex pairs, some digits corrupted, checksum trailer
    task automatic add_console_packet(input int unsigned mode);
        int unsigned pairs;
        logic [7:0]  c;
        pairs = $urandom_range(0, 5);
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_START, mode);
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_CONSOLE, mode);
        repeat (2 * pairs)
        begin
            c = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : rand_hex_char();
            add_item(dlpf_pkg::OP_RX_BYTE, c, mode);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            add_item(dlpf_pkg::OP_RX_BYTE, rand_hex_char(), mode);
        end
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_END, mode);
        add_item(dlpf_pkg::OP_RX_BYTE, rand_hex_char(), mode);
        add_item(dlpf_pkg::OP_RX_BYTE, rand_hex_char(), mode);
    endtask

    // packet of another kind, skipped to its end mark
    task automatic add_other_packet(input int unsigned mode);
        logic [7:0] c;
        c = rand_plain_char();
        if (c == dlpf_pkg::CHR_CONSOLE)
        begin
            c = 8'h71;
        end
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_START, mode);
        add_item(dlpf_pkg::OP_RX_BYTE, c, mode);
        repeat ($urandom_range(0, 5))
        begin
            add_item(dlpf_pkg::OP_RX_BYTE, rand_plain_char(), mode);
        end
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_END, mode);
        add_item(dlpf_pkg::OP_RX_BYTE, rand_hex_char(), mode);
        add_item(dlpf_pkg::OP_RX_BYTE, rand_hex_char(), mode);
    endtask

    // driver: predicts on acceptance, then loads the next pending item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                frame_item(cmd_ch.operation, cmd_ch.data_byte);
                items_taken++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= send_gap_pct(pending_items[0].mode))
                begin
                    cmd_ch.operation <= pending_items[0].op;
                    cmd_ch.data_byte <= pending_items[0].data;
                    cmd_ch.valid     <= 1'b1;
                    stall_mode       <= pending_items[0].mode;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result with the oldest expected one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h", res_ch.out_byte);
                    error_count++;
                end
                else
                begin
                    next_due = due_results.pop_front();
                    if (res_ch.channel !== next_due.channel)
                    begin
                        $error("channel: expected %0d, got %0d",
                               next_due.channel, res_ch.channel);
                        error_count++;
                    end
                    if (res_ch.out_byte !== next_due.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               next_due.out_byte, res_ch.out_byte);
                        error_count++;
                    end
                    if (res_ch.hex_error !== next_due.hex_error)
                    begin
                        $error("hex_error: expected %0d, got %0d",
                               next_due.hex_error, res_ch.hex_error);
                        error_count++;
                    end
                    if (res_ch.run_last !== next_due.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d",
                               next_due.run_last, res_ch.run_last);
                        error_count++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct(stall_mode));
        end
    end

    // watchdog: cycles with no item accepted on either side
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned mode;
        int unsigned pick;

        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = dlpf_pkg::OP_TX_BYTE;
        cmd_ch.data_byte = 8'd0;
        res_ch.ready     = 1'b0;
        items_total      = 0;
        items_taken      = 0;
        stall_mode       = MODE_NONE;
        quiet_cycles     = 0;
        error_count      = 0;
        tx_open          = 1'b0;
        tx_sum           = 8'd0;
        rx_phase         = dlpf_pkg::PH_IDLE;
        held_nibble      = 4'd0;
        held_bad         = 1'b0;

        // transmit: extremes, framing marks in the payload, empty packet
        add_item(dlpf_pkg::OP_TX_BYTE, 8'h00, MODE_NONE);
        add_item(dlpf_pkg::OP_TX_BYTE, 8'hFF, MODE_NONE);
        add_item(dlpf_pkg::OP_TX_BYTE, dlpf_pkg::CHR_START, MODE_NONE);
        add_item(dlpf_pkg::OP_TX_BYTE, dlpf_pkg::CHR_END, MODE_NONE);
        add_item(dlpf_pkg::OP_TX_CLOSE, 8'h00, MODE_NONE);
        add_item(dlpf_pkg::OP_TX_CLOSE, 8'hFF, MODE_NONE);
        // unused operation code and a stray byte while idle
        add_item(OP_NOP, 8'hAA, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h78, MODE_NONE);
        // console packet: lower and upper case pair, then a pair with a bad high digit
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_START, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_CONSOLE, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h61, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h46, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h47, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h39, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h33, MODE_NONE);
        // restart inside a packet drops the held high digit
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_START, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_CONSOLE, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h43, MODE_NONE);
        // end mark as the low digit
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_END, MODE_NONE);
        // skipped packet, then a packet that ends at its first character
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_START, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, 8'h71, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_END, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_START, MODE_NONE);
        add_item(dlpf_pkg::OP_RX_BYTE, dlpf_pkg::CHR_END, MODE_NONE);
        add_item(OP_NOP, 8'h55, MODE_NONE);

        // random part, idling mode changes every stretch
        random_taken = 0;
        while (random_taken < RANDOM_ITEMS)
        begin
            mode = (random_taken / 58) % 4;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                add_tx_packet(mode);
            else if (pick < 65)
                add_console_packet(mode);
            else if (pick < 80)
                add_other_packet(mode);
            else
                add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), mode);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while ((items_taken < items_total || due_results.size() != 0) &&
               quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        if (quiet_cycles < QUIET_LIMIT)
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
        end
        else
        begin
            $error("timeout: %0d items and %0d results outstanding",
                   items_total - items_taken, due_results.size());
        end

        if (quiet_cycles < QUIET_LIMIT && error_count == 0 && due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
